// File: hdl/fair_share_dispatcher_macros.svh
// assertion macros used by the checker file
`ifndef FAIR_SHARE_DISPATCHER_MACROS_SVH
`define FAIR_SHARE_DISPATCHER_MACROS_SVH

// same-cycle implication, held off during reset
`define FSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define FSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/fsd_pkg.sv
// ----------------------------------------------------------------------------
// fsd_pkg
// Shared types, widths and codes of the fair share dispatcher.
// ----------------------------------------------------------------------------
package fsd_pkg;

  localparam int MAX_JOBS = 64;
  localparam int SLOT_W   = $clog2(MAX_JOBS);
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);
  localparam int HIDX_W   = CNT_W + 1;

  localparam int ID_W    = 16;
  localparam int WT_W    = 17;
  localparam int LEN_W   = 24;
  localparam int TIME_W  = 32;
  localparam int CFG_W   = 20;
  localparam int VRUN_W  = 48;
  localparam int TOTAL_W = WT_W + SLOT_W;
  localparam int DIVD_W  = CFG_W + LEN_W;
  localparam int DIVS_W  = TOTAL_W;
  localparam int DCNT_W  = $clog2(DIVD_W + 1);
  localparam int CIDX_W  = 2;

  // register indexes of the configuration port
  localparam logic [CIDX_W-1:0] CFG_LATENCY     = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_GRANULARITY = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_DEFAULT_WT  = 2'd2;

  localparam logic [CFG_W-1:0] LATENCY_RST     = 20'd48;
  localparam logic [CFG_W-1:0] GRANULARITY_RST = 20'd6;
  localparam logic [CFG_W-1:0] DEFAULT_WT_RST  = 20'd1024;

  typedef enum logic [0:0] {
    CMD_ADD      = 1'b0,
    CMD_DISPATCH = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_ADDED      = 2'd0,
    ST_DISPATCHED = 2'd1,
    ST_FULL       = 2'd2,
    ST_EMPTY      = 2'd3
  } status_t;

  typedef struct packed {
    logic               command;
    logic [ID_W-1:0]    job_id;
    logic [WT_W-1:0]    job_weight;
    logic [LEN_W-1:0]   job_length;
  } item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ID_W-1:0]    run_id;
    logic [LEN_W-1:0]   slice;
    logic [TIME_W-1:0]  start_time;
    logic               job_done;
  } result_t;

  typedef struct packed {
    logic [ID_W-1:0]    ident;
    logic [WT_W-1:0]    wt;
    logic [LEN_W-1:0]   len;
    logic [LEN_W-1:0]   ran;
  } job_rec_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [VRUN_W-1:0]  key;
  } heap_entry_t;

  typedef enum logic [1:0] {
    HOP_APPEND,
    HOP_PUSH,
    HOP_BUILD,
    HOP_POP
  } heap_op_t;

  typedef struct packed {
    logic               valid;
    heap_op_t           op;
    heap_entry_t        entry;
  } heap_req_t;

  typedef struct packed {
    logic               done;
    heap_entry_t        root;
    logic [CNT_W-1:0]   count;
  } heap_resp_t;

  typedef enum logic [3:0] {
    H_IDLE,
    H_BLD_RD,
    H_BLD_LD,
    H_SD_RDL,
    H_SD_RDR,
    H_SD_CMP,
    H_POP_RD0,
    H_POP_RDL,
    H_POP_LD,
    H_SU_CHK,
    H_SU_CMP,
    H_DONE
  } heap_state_t;

  typedef enum logic [3:0] {
    T_IDLE,
    T_ADD_WAIT,
    T_BUILD_WAIT,
    T_CHECK,
    T_POP_WAIT,
    T_JRD,
    T_JLD,
    T_DIV1_GO,
    T_DIV1,
    T_SLICE,
    T_DIV2_GO,
    T_DIV2,
    T_VRUN,
    T_PUSH_WAIT,
    T_FINISH
  } top_state_t;

endpackage

// File: hdl/fsd_divider.sv
// ----------------------------------------------------------------------------
// fsd_divider
// Restoring divider, one quotient bit per cycle, shared by both divisions.
// ----------------------------------------------------------------------------
module fsd_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [fsd_pkg::DIVD_W-1:0]    dividend,
  input  logic [fsd_pkg::DIVS_W-1:0]    divisor,
  output logic                          done,
  output logic [fsd_pkg::DIVD_W-1:0]    quotient
);

  logic [fsd_pkg::DCNT_W-1:0] cnt;
  logic [fsd_pkg::DIVS_W-1:0] dvsr;
  logic [fsd_pkg::DIVS_W-1:0] rem;
  logic [fsd_pkg::DIVS_W:0]   shifted;
  logic                       fits;

  // trial subtract of the next partial remainder
  always_comb begin
    shifted = {rem, quotient[fsd_pkg::DIVD_W-1]};
    fits    = (shifted >= {1'b0, dvsr});
  end

  // control: step counter and completion strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        cnt <= fsd_pkg::DCNT_W'(fsd_pkg::DIVD_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == fsd_pkg::DCNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (go) begin
      dvsr     <= divisor;
      rem      <= '0;
      quotient <= dividend;
    end else if (cnt != '0) begin
      if (fits) begin
        rem <= fsd_pkg::DIVS_W'(shifted - {1'b0, dvsr});
      end else begin
        rem <= shifted[fsd_pkg::DIVS_W-1:0];
      end
      quotient <= {quotient[fsd_pkg::DIVD_W-2:0], fits};
    end
  end

endmodule

// File: hdl/fsd_heap.sv
// ----------------------------------------------------------------------------
// fsd_heap
// Min-heap of job slots keyed by virtual runtime, one memory read per cycle.
// ----------------------------------------------------------------------------
module fsd_heap (
  input  logic                clk,
  input  logic                rst,
  input  fsd_pkg::heap_req_t  req,
  output fsd_pkg::heap_resp_t resp
);

  fsd_pkg::heap_state_t state, state_next;
  fsd_pkg::heap_entry_t mem [fsd_pkg::MAX_JOBS];
  fsd_pkg::heap_entry_t rdata;

  logic [fsd_pkg::CNT_W-1:0]  count, count_next;
  logic [fsd_pkg::CNT_W-1:0]  bi, bi_next;
  logic [fsd_pkg::SLOT_W-1:0] pos, pos_next;
  fsd_pkg::heap_entry_t       cur, cur_next;
  fsd_pkg::heap_entry_t       lent, lent_next;
  fsd_pkg::heap_entry_t       root, root_next;
  logic                       building, building_next;

  logic                       mem_we;
  logic [fsd_pkg::SLOT_W-1:0] mem_waddr;
  fsd_pkg::heap_entry_t       mem_wdata;
  logic [fsd_pkg::SLOT_W-1:0] rd_addr;

  logic [fsd_pkg::HIDX_W-1:0] l_idx, r_idx, cnt_ext;
  logic [fsd_pkg::SLOT_W-1:0] par;
  logic                       use_l, use_r;
  logic [fsd_pkg::VRUN_W-1:0] min_key;

  // child and parent positions
  always_comb begin
    l_idx   = fsd_pkg::HIDX_W'({pos, 1'b1});
    r_idx   = l_idx + 1'b1;
    cnt_ext = fsd_pkg::HIDX_W'(count);
    par     = (pos - 1'b1) >> 1;
    use_l   = (l_idx < cnt_ext) && (lent.key < cur.key);
    min_key = use_l ? lent.key : cur.key;
    use_r   = (r_idx < cnt_ext) && (rdata.key < min_key);
  end

  // next state and memory control
  always_comb begin
    state_next    = state;
    count_next    = count;
    bi_next       = bi;
    pos_next      = pos;
    cur_next      = cur;
    lent_next     = lent;
    root_next     = root;
    building_next = building;
    mem_we        = 1'b0;
    mem_waddr     = pos;
    mem_wdata     = cur;
    rd_addr       = '0;
    unique case (state)
      fsd_pkg::H_IDLE: begin
        if (req.valid) begin
          unique case (req.op)
            fsd_pkg::HOP_APPEND: begin
              mem_we     = 1'b1;
              mem_waddr  = count[fsd_pkg::SLOT_W-1:0];
              mem_wdata  = req.entry;
              count_next = count + 1'b1;
              state_next = fsd_pkg::H_DONE;
            end
            fsd_pkg::HOP_PUSH: begin
              cur_next   = req.entry;
              pos_next   = count[fsd_pkg::SLOT_W-1:0];
              count_next = count + 1'b1;
              state_next = fsd_pkg::H_SU_CHK;
            end
            fsd_pkg::HOP_BUILD: begin
              bi_next       = count >> 1;
              building_next = 1'b1;
              state_next    = fsd_pkg::H_BLD_RD;
            end
            fsd_pkg::HOP_POP: begin
              building_next = 1'b0;
              state_next    = fsd_pkg::H_POP_RD0;
            end
            default: state_next = fsd_pkg::H_IDLE;
          endcase
        end
      end
      fsd_pkg::H_BLD_RD: begin
        rd_addr    = bi[fsd_pkg::SLOT_W-1:0];
        state_next = fsd_pkg::H_BLD_LD;
      end
      fsd_pkg::H_BLD_LD: begin
        cur_next   = rdata;
        pos_next   = bi[fsd_pkg::SLOT_W-1:0];
        state_next = fsd_pkg::H_SD_RDL;
      end
      fsd_pkg::H_SD_RDL: begin
        rd_addr    = l_idx[fsd_pkg::SLOT_W-1:0];
        state_next = fsd_pkg::H_SD_RDR;
      end
      fsd_pkg::H_SD_RDR: begin
        rd_addr    = r_idx[fsd_pkg::SLOT_W-1:0];
        lent_next  = rdata;
        state_next = fsd_pkg::H_SD_CMP;
      end
      fsd_pkg::H_SD_CMP: begin
        // move the smaller child up into the hole, or settle here
        mem_we = 1'b1;
        if (use_r) begin
          mem_wdata  = rdata;
          pos_next   = r_idx[fsd_pkg::SLOT_W-1:0];
          state_next = fsd_pkg::H_SD_RDL;
        end else if (use_l) begin
          mem_wdata  = lent;
          pos_next   = l_idx[fsd_pkg::SLOT_W-1:0];
          state_next = fsd_pkg::H_SD_RDL;
        end else if (building && bi != '0) begin
          bi_next    = bi - 1'b1;
          state_next = fsd_pkg::H_BLD_RD;
        end else begin
          state_next = fsd_pkg::H_DONE;
        end
      end
      fsd_pkg::H_POP_RD0: begin
        rd_addr    = '0;
        state_next = fsd_pkg::H_POP_RDL;
      end
      fsd_pkg::H_POP_RDL: begin
        rd_addr    = fsd_pkg::SLOT_W'(count - 1'b1);
        root_next  = rdata;
        state_next = fsd_pkg::H_POP_LD;
      end
      fsd_pkg::H_POP_LD: begin
        cur_next   = rdata;
        count_next = count - 1'b1;
        pos_next   = '0;
        state_next = fsd_pkg::H_SD_RDL;
      end
      fsd_pkg::H_SU_CHK: begin
        rd_addr = par;
        if (pos == '0) begin
          mem_we     = 1'b1;
          state_next = fsd_pkg::H_DONE;
        end else begin
          state_next = fsd_pkg::H_SU_CMP;
        end
      end
      fsd_pkg::H_SU_CMP: begin
        // pull a larger parent down, or place the new entry
        mem_we = 1'b1;
        if (rdata.key > cur.key) begin
          mem_wdata  = rdata;
          pos_next   = par;
          state_next = fsd_pkg::H_SU_CHK;
        end else begin
          state_next = fsd_pkg::H_DONE;
        end
      end
      fsd_pkg::H_DONE: begin
        state_next = fsd_pkg::H_IDLE;
      end
      default: state_next = fsd_pkg::H_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= fsd_pkg::H_IDLE;
      count    <= '0;
      building <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      building <= building_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    bi   <= bi_next;
    pos  <= pos_next;
    cur  <= cur_next;
    lent <= lent_next;
    root <= root_next;
  end

  // heap memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[rd_addr];
  end

  always_comb begin
    resp.done  = (state == fsd_pkg::H_DONE);
    resp.root  = root;
    resp.count = count;
  end

endmodule

// File: hdl/fair_share_dispatcher.sv
// ----------------------------------------------------------------------------
// fair_share_dispatcher
// Job table plus min-heap dispatcher with weighted slices and virtual runtime.
// ----------------------------------------------------------------------------
// accept to result strobe: an add appends to the heap before it is built, else
//   pushes and sifts up one level per step; a full table skips the heap.
// dispatch: one divide of a 44-bit dividend when the job finishes, else a second
//   divide and reinsertion; the first dispatch adds the heap build, a sift-down
//   of each of count/2+1 nodes; a dispatch with no job ends at the empty check.
// one command at a time, next taken in the strobe cycle; rst resets control only.
module fair_share_dispatcher (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  fsd_pkg::item_t              item,
  output logic                        busy,
  output logic                        done,
  output fsd_pkg::result_t            result,
  input  logic                        cfg_we,
  input  logic [fsd_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [fsd_pkg::CFG_W-1:0]   cfg_data
);

  fsd_pkg::top_state_t state, state_next;

  logic [fsd_pkg::CFG_W-1:0]   latency, granularity, default_wt;
  logic [fsd_pkg::CNT_W-1:0]   loaded, left;
  logic [fsd_pkg::TOTAL_W-1:0] total;
  logic [fsd_pkg::TIME_W-1:0]  now_time;
  logic                        built;

  fsd_pkg::job_rec_t           job;
  fsd_pkg::heap_entry_t        cur;
  logic [fsd_pkg::DIVD_W-1:0]  prod;
  logic [fsd_pkg::DIVS_W-1:0]  dvsr;

  fsd_pkg::job_rec_t           jt_mem [fsd_pkg::MAX_JOBS];
  fsd_pkg::job_rec_t           jt_rdata, jt_wdata;
  logic                        jt_we;
  logic [fsd_pkg::SLOT_W-1:0]  jt_waddr;

  fsd_pkg::heap_req_t          hreq;
  fsd_pkg::heap_resp_t         hresp;
  logic                        div_go, div_done;
  logic [fsd_pkg::DIVD_W-1:0]  quo;

  logic [fsd_pkg::WT_W-1:0]    in_wt;
  logic [fsd_pkg::LEN_W-1:0]   in_len;
  logic                        accept, full;
  logic [fsd_pkg::DIVD_W-1:0]  sl_floor;
  logic [fsd_pkg::LEN_W-1:0]   rem, sl, ran_new;
  logic [fsd_pkg::VRUN_W:0]    vsum;
  logic [fsd_pkg::VRUN_W-1:0]  vrun_new;

  assign accept = start && !busy;
  assign busy   = (state != fsd_pkg::T_IDLE);
  assign full   = (loaded == fsd_pkg::CNT_W'(fsd_pkg::MAX_JOBS));

  // zero weight and length are taken as one
  always_comb begin
    in_wt  = (item.job_weight == '0) ? fsd_pkg::WT_W'(1) : item.job_weight;
    in_len = (item.job_length == '0) ? fsd_pkg::LEN_W'(1) : item.job_length;
  end

  // slice: floor at granularity, clip to remaining work
  always_comb begin
    sl_floor = (quo < fsd_pkg::DIVD_W'(granularity)) ? fsd_pkg::DIVD_W'(granularity) : quo;
    rem      = job.len - job.ran;
    sl       = (sl_floor > fsd_pkg::DIVD_W'(rem)) ? rem : sl_floor[fsd_pkg::LEN_W-1:0];
    ran_new  = job.ran + sl;
  end

  // saturating virtual runtime charge
  always_comb begin
    vsum     = {1'b0, cur.key} + (fsd_pkg::VRUN_W + 1)'(quo);
    vrun_new = vsum[fsd_pkg::VRUN_W] ? '1 : vsum[fsd_pkg::VRUN_W-1:0];
  end

  // next state and unit requests
  always_comb begin
    state_next   = state;
    hreq.valid   = 1'b0;
    hreq.op      = fsd_pkg::HOP_APPEND;
    hreq.entry   = '{slot: loaded[fsd_pkg::SLOT_W-1:0], key: '0};
    div_go       = 1'b0;
    jt_we        = 1'b0;
    jt_waddr     = cur.slot;
    jt_wdata     = '{ident: job.ident, wt: job.wt, len: job.len, ran: ran_new};
    unique case (state)
      fsd_pkg::T_IDLE: begin
        if (accept) begin
          if (item.command == fsd_pkg::CMD_ADD) begin
            if (full) begin
              state_next = fsd_pkg::T_FINISH;
            end else begin
              jt_we      = 1'b1;
              jt_waddr   = loaded[fsd_pkg::SLOT_W-1:0];
              jt_wdata   = '{ident: item.job_id, wt: in_wt, len: in_len, ran: '0};
              hreq.valid = 1'b1;
              hreq.op    = built ? fsd_pkg::HOP_PUSH : fsd_pkg::HOP_APPEND;
              state_next = fsd_pkg::T_ADD_WAIT;
            end
          end else if (!built) begin
            hreq.valid = 1'b1;
            hreq.op    = fsd_pkg::HOP_BUILD;
            state_next = fsd_pkg::T_BUILD_WAIT;
          end else begin
            state_next = fsd_pkg::T_CHECK;
          end
        end
      end
      fsd_pkg::T_ADD_WAIT: begin
        if (hresp.done) state_next = fsd_pkg::T_FINISH;
      end
      fsd_pkg::T_BUILD_WAIT: begin
        if (hresp.done) state_next = fsd_pkg::T_CHECK;
      end
      fsd_pkg::T_CHECK: begin
        if (hresp.count == '0 || total == '0) begin
          state_next = fsd_pkg::T_FINISH;
        end else begin
          hreq.valid = 1'b1;
          hreq.op    = fsd_pkg::HOP_POP;
          state_next = fsd_pkg::T_POP_WAIT;
        end
      end
      fsd_pkg::T_POP_WAIT: begin
        if (hresp.done) state_next = fsd_pkg::T_JRD;
      end
      fsd_pkg::T_JRD:     state_next = fsd_pkg::T_JLD;
      fsd_pkg::T_JLD:     state_next = fsd_pkg::T_DIV1_GO;
      fsd_pkg::T_DIV1_GO: begin
        div_go     = 1'b1;
        state_next = fsd_pkg::T_DIV1;
      end
      fsd_pkg::T_DIV1: begin
        if (div_done) state_next = fsd_pkg::T_SLICE;
      end
      fsd_pkg::T_SLICE: begin
        jt_we      = 1'b1;
        state_next = (ran_new == job.len) ? fsd_pkg::T_FINISH : fsd_pkg::T_DIV2_GO;
      end
      fsd_pkg::T_DIV2_GO: begin
        div_go     = 1'b1;
        state_next = fsd_pkg::T_DIV2;
      end
      fsd_pkg::T_DIV2: begin
        if (div_done) state_next = fsd_pkg::T_VRUN;
      end
      fsd_pkg::T_VRUN: begin
        hreq.valid = 1'b1;
        hreq.op    = fsd_pkg::HOP_PUSH;
        hreq.entry = '{slot: cur.slot, key: vrun_new};
        state_next = fsd_pkg::T_PUSH_WAIT;
      end
      fsd_pkg::T_PUSH_WAIT: begin
        if (hresp.done) state_next = fsd_pkg::T_FINISH;
      end
      fsd_pkg::T_FINISH:  state_next = fsd_pkg::T_IDLE;
      default:            state_next = fsd_pkg::T_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fsd_pkg::T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      latency     <= fsd_pkg::LATENCY_RST;
      granularity <= fsd_pkg::GRANULARITY_RST;
      default_wt  <= fsd_pkg::DEFAULT_WT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fsd_pkg::CFG_LATENCY:     latency     <= cfg_data;
        fsd_pkg::CFG_GRANULARITY: granularity <= cfg_data;
        fsd_pkg::CFG_DEFAULT_WT:  default_wt  <= cfg_data;
        default: ;
      endcase
    end
  end

  // scheduler bookkeeping and result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded   <= '0;
      left     <= '0;
      total    <= '0;
      now_time <= '0;
      built    <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= (state == fsd_pkg::T_FINISH);
      if (state == fsd_pkg::T_IDLE && accept && item.command == fsd_pkg::CMD_ADD && !full) begin
        loaded <= loaded + 1'b1;
        left   <= left + 1'b1;
        total  <= total + fsd_pkg::TOTAL_W'(in_wt);
      end
      if (state == fsd_pkg::T_BUILD_WAIT && hresp.done) begin
        built <= 1'b1;
      end
      if (state == fsd_pkg::T_SLICE) begin
        now_time <= now_time + fsd_pkg::TIME_W'(sl);
        if (ran_new == job.len && left != '0) begin
          left <= left - 1'b1;
        end
      end
    end
  end

  // datapath registers and result fields
  always_ff @(posedge clk) begin
    unique case (state)
      fsd_pkg::T_IDLE: begin
        if (accept) begin
          result <= '{status: (item.command == fsd_pkg::CMD_DISPATCH) ? fsd_pkg::ST_EMPTY :
                              (full ? fsd_pkg::ST_FULL : fsd_pkg::ST_ADDED),
                      default: '0};
        end
      end
      fsd_pkg::T_CHECK:   result.status <= fsd_pkg::ST_EMPTY;
      fsd_pkg::T_JRD:     cur <= hresp.root;
      fsd_pkg::T_JLD: begin
        job  <= jt_rdata;
        prod <= fsd_pkg::DIVD_W'(jt_rdata.wt * latency);
        dvsr <= total;
      end
      fsd_pkg::T_SLICE: begin
        job.ran           <= ran_new;
        prod              <= fsd_pkg::DIVD_W'(default_wt * ran_new);
        dvsr              <= fsd_pkg::DIVS_W'(job.wt);
        result.status     <= fsd_pkg::ST_DISPATCHED;
        result.run_id     <= job.ident;
        result.slice      <= sl;
        result.start_time <= now_time;
        result.job_done   <= (ran_new == job.len);
      end
      default: ;
    endcase
  end

  // job table memory
  always_ff @(posedge clk) begin
    if (jt_we) begin
      jt_mem[jt_waddr] <= jt_wdata;
    end
    jt_rdata <= jt_mem[hresp.root.slot];
  end

  fsd_heap u_heap (
    .clk  (clk),
    .rst  (rst),
    .req  (hreq),
    .resp (hresp)
  );

  fsd_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (prod),
    .divisor  (dvsr),
    .done     (div_done),
    .quotient (quo)
  );

endmodule

// File: hdl/fsd_checker.sv
// ----------------------------------------------------------------------------
// fsd_checker
// Port-level checks of the dispatcher's command and result behavior.
// ----------------------------------------------------------------------------
`include "fair_share_dispatcher_macros.svh"

module fsd_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input fsd_pkg::result_t result
);

  logic not_dispatch;
  logic fields_clear;

  // job fields of a result that carries no dispatch
  assign not_dispatch = (result.status != fsd_pkg::ST_DISPATCHED);
  assign fields_clear = (result.run_id == '0) && (result.slice == '0) &&
                        (result.start_time == '0) && !result.job_done;

  // a result beat closes a busy period
  `FSD_ASSERT_NOW(a_done_after_busy, done, $past(busy) && !busy, "beat without busy period")

  // an accepted command keeps the block busy
  `FSD_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "accepted command not busy")

  // only a dispatch carries job fields
  `FSD_ASSERT_NOW(a_idle_fields, done && not_dispatch, fields_clear, "job fields set")

  // a job cannot finish on an empty slice
  `FSD_ASSERT_NOW(a_done_slice, done && result.job_done, result.slice != '0, "empty final slice")

endmodule

bind fair_share_dispatcher fsd_checker u_fsd_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
